// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Widths, list marker, pair-bit bases and the link-memory request type.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
	localparam int NumPages  = 1024;
	localparam int NumOrders = 6;
	localparam int PageW     = 10;
	localparam int LinkW     = 11;
	localparam int CntW      = 11;
	localparam int OrdW      = 3;
	localparam logic [LinkW-1:0] NilLink = LinkW'(NumPages);
	localparam logic [CntW-1:0]  FreeMax = CntW'(2 * NumPages - 1);

	localparam logic [1:0] CfgPool = 2'd0;
	localparam logic [1:0] CfgLow  = 2'd1;
	localparam logic [1:0] CfgHigh = 2'd2;

	localparam logic [OrdW-1:0] OrdTooBig = OrdW'(NumOrders);

	// base of the pair-bit region for one order
	function automatic logic [PageW:0] pair_base(input logic [OrdW-1:0] k);
		logic [PageW:0] b;
		b = '0;
		for (int i = 0; i < NumOrders; i++) begin
			if (OrdW'(i) < k) b = b + (PageW+1)'(NumPages >> (i + 1));
		end
		return b;
	endfunction

	// link memory request: one read or write per cycle
	typedef struct packed {
		logic             we;
		logic             sel_prev;
		logic [PageW-1:0] addr;
		logic [LinkW-1:0] wdata;
	} link_req_t;
endpackage
`default_nettype wire

// ===== rtl/buddy_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_top: binary buddy allocator over a page pool
// Allocate scans the free lists upward from the requested order, unlinks and
// toggles the head block, then per split pushes a lower half and toggles it;
// free toggles, unlinks the buddy and moves up per merged level, then pushes.
// Throughput: one command at a time; s_tready returns the cycle after the
// result beat is taken. Reset: lists empty, free count zero, registers
// 1024/20/30; the pair bits are cleared by a pass with s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_page_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // page_index[9:0], block_order[12:10]
	input  wire logic        s_tuser,  // cmd[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // success[0], granted_page[10:1], free_count[21:11],
	                                   // pressure[23:22]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_wdata
);
	localparam int PW = bpa_pkg::PageW;
	localparam int LW = bpa_pkg::LinkW;
	localparam int OW = bpa_pkg::OrdW;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_SCAN  = 14'b00000000000010,
		S_UNRN  = 14'b00000000000100, // read next of block to unlink
		S_UNRP  = 14'b00000000001000, // read prev
		S_UNW1  = 14'b00000000010000, // fix head or pv.next
		S_UNW2  = 14'b00000000100000, // fix nx.prev
		S_TOG   = 14'b00000001000000, // read pair bit
		S_TOGW  = 14'b00000010000000, // flip pair bit, decide next
		S_PUW1  = 14'b00000100000000, // push: write next
		S_PUW2  = 14'b00001000000000, // push: write prev
		S_PUW3  = 14'b00010000000000, // push: old head prev
		S_SPLIT = 14'b00100000000000,
		S_DONE  = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic [LW-1:0] pool_q, low_q, high_q, cnt_q;
	logic          plenty_q;
	logic [LW-1:0] head_q [bpa_pkg::NumOrders];
	logic          cmd_q, ok_q;
	logic [OW-1:0] ord_q, k_q;
	logic [LW-1:0] p_q, nx_q;   // working block, link scratch
	logic [PW-1:0] gr_q;
	logic          after_q;     // alloc: set once a lower half has been pushed
	logic [23:0]   out_q;

	bpa_pkg::link_req_t req;
	logic [LW-1:0] rdata;
	logic          prd, pflip, pold, pready;
	logic [PW-1:0] paddr;
	logic [PW:0]   pidx;

	bpa_link_mem u_link (.clk(clk), .req(req), .rdata(rdata));
	bpa_pair_mem u_pair (.clk(clk), .arst_n(arst_n), .rd(prd), .flip(pflip),
		.addr(paddr), .old(pold), .ready(pready));

	wire logic p_ok  = (p_q < LW'(bpa_pkg::NumPages));
	wire logic nx_ok = (nx_q < LW'(bpa_pkg::NumPages));
	wire logic r_ok  = (rdata < LW'(bpa_pkg::NumPages));
	wire logic [LW-1:0] blk = LW'(1) << k_q;
	wire logic [LW-1:0] osz = LW'(1) << ord_q;
	logic [LW-1:0] pv_q;
	logic [LW-1:0] buddy;
	assign buddy = p_q ^ blk;

	// pair index for (p_q, k_q)
	assign pidx  = bpa_pkg::pair_base(k_q) + (PW+1)'(p_q >> (k_q + OW'(1)));
	assign paddr = pidx[PW-1:0];

	// pressure from the final count
	logic [LW-1:0] cnt_n;
	logic [1:0]    lvl;
	always_comb begin
		cnt_n = cnt_q;
		lvl = {1'b0, plenty_q};
		if (cnt_q < low_q) lvl = 2'd0;
		else if (cnt_q > high_q) lvl = 2'd2;
	end

	always_comb begin
		req = '0;
		prd = 1'b0;
		pflip = 1'b0;
		unique case (state_q)
			S_UNRN: begin req.addr = p_q[PW-1:0]; end
			S_UNRP: begin req.addr = p_q[PW-1:0]; req.sel_prev = 1'b1; end
			S_UNW1: begin
				req.we = (head_q[k_q] != p_q) && r_ok;
				req.addr = rdata[PW-1:0];
				req.wdata = nx_q;
			end
			S_UNW2: begin
				req.we = nx_ok; req.sel_prev = 1'b1;
				req.addr = nx_q[PW-1:0];
				req.wdata = pv_q < LW'(bpa_pkg::NumPages) ? pv_q : bpa_pkg::NilLink;
			end
			S_TOG: begin prd = pidx <= (PW+1)'(bpa_pkg::NumPages - 1); end
			S_TOGW: begin pflip = pidx <= (PW+1)'(bpa_pkg::NumPages - 1); end
			S_PUW1: begin
				req.we = p_ok; req.addr = p_q[PW-1:0];
				req.wdata = (head_q[k_q] < LW'(bpa_pkg::NumPages)) ? head_q[k_q]
					: bpa_pkg::NilLink;
			end
			S_PUW2: begin
				req.we = p_ok; req.sel_prev = 1'b1; req.addr = p_q[PW-1:0];
				req.wdata = bpa_pkg::NilLink;
			end
			S_PUW3: begin
				req.we = p_ok && (head_q[k_q] < LW'(bpa_pkg::NumPages));
				req.sel_prev = 1'b1; req.addr = head_q[k_q][PW-1:0];
				req.wdata = p_q;
			end
			default: ;
		endcase
	end

	// hold off input beats until the pair-bit clearing pass is over
	assign s_tready = (state_q == S_IDLE) && pready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pool_q <= 11'd1024; low_q <= 11'd20; high_q <= 11'd30;
			cnt_q <= '0; plenty_q <= 1'b1;
			for (int i = 0; i < bpa_pkg::NumOrders; i++) head_q[i] <= bpa_pkg::NilLink;
			cmd_q <= 1'b0; ok_q <= 1'b0; ord_q <= '0; k_q <= '0;
			p_q <= '0; nx_q <= '0; pv_q <= '0; gr_q <= '0; after_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bpa_pkg::CfgPool: pool_q <= cfg_wdata;
					bpa_pkg::CfgLow:  low_q <= cfg_wdata;
					bpa_pkg::CfgHigh: high_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					cmd_q <= s_tuser;
					ord_q <= s_tdata[12:10];
					k_q <= s_tdata[12:10];
					ok_q <= 1'b0; gr_q <= '0; after_q <= 1'b0;
					p_q <= {1'b0, s_tdata[9:0] & ~((PW'(1) << s_tdata[12:10]) - PW'(1))};
					if (s_tdata[12:10] >= bpa_pkg::OrdTooBig) state_q <= S_DONE;
					else if (!s_tuser) state_q <= S_SCAN;
					else if ({1'b0, s_tdata[9:0]} < pool_q) begin
						// accept the free, then try to merge
						ok_q <= 1'b1;
						cnt_q <= (12'(cnt_q) + 12'(LW'(1) << s_tdata[12:10]) > 12'(bpa_pkg::FreeMax))
							? bpa_pkg::FreeMax : cnt_q + (LW'(1) << s_tdata[12:10]);
						state_q <= (s_tdata[12:10] == OW'(bpa_pkg::NumOrders - 1)) ? S_PUW1 : S_TOG;
					end else state_q <= S_DONE;
				end
				S_SCAN: begin
					if (head_q[k_q] < LW'(bpa_pkg::NumPages)) begin
						p_q <= head_q[k_q];
						ok_q <= 1'b1;
						cnt_q <= (cnt_q >= osz) ? cnt_q - osz : '0;
						state_q <= S_UNRN;
					end else if (k_q == OW'(bpa_pkg::NumOrders - 1)) state_q <= S_DONE;
					else k_q <= k_q + OW'(1);
				end
				S_UNRN: state_q <= S_UNRP;
				S_UNRP: begin
					nx_q <= r_ok ? rdata : bpa_pkg::NilLink;
					state_q <= S_UNW1;
				end
				S_UNW1: begin
					pv_q <= rdata;
					if (head_q[k_q] == p_q) head_q[k_q] <= nx_q;
					state_q <= S_UNW2;
				end
				S_UNW2: begin
					if (cmd_q) begin
						// buddy unlinked: move up one order, align to the merged block
						k_q <= k_q + OW'(1);
						p_q <= p_q & ~((blk << 1) - LW'(1));
						state_q <= (k_q + OW'(1) == OW'(bpa_pkg::NumOrders - 1)) ? S_PUW1 : S_TOG;
					end else state_q <= S_TOG;
				end
				S_TOG: state_q <= S_TOGW;
				S_TOGW: begin
					if (cmd_q) begin
						if (pold) begin
							// buddy is free: unlink it next
							p_q <= buddy;
							state_q <= S_UNRN;
						end else state_q <= S_PUW1;
					end else begin
						// split step: after a lower half, advance to the upper part
						after_q <= 1'b0;
						if (k_q > ord_q) begin
							k_q <= k_q - OW'(1);
							if (after_q) p_q <= p_q + blk;
							state_q <= S_PUW1;
						end else begin
							gr_q <= after_q ? PW'(p_q + blk) : p_q[PW-1:0];
							state_q <= S_DONE;
						end
					end
				end
				S_PUW1: state_q <= S_PUW2;
				S_PUW2: state_q <= S_PUW3;
				S_PUW3: begin
					if (p_ok) head_q[k_q] <= p_q;
					if (!cmd_q) after_q <= 1'b1;
					state_q <= cmd_q ? S_DONE : S_SPLIT;
				end
				S_SPLIT: state_q <= S_TOG; // toggle (p, k) then step
				S_DONE: begin
					out_q <= {lvl, cnt_n, gr_q, ok_q};
					if (cnt_q < low_q) plenty_q <= 1'b0;
					else if (cnt_q > high_q) plenty_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bpa_link_mem.sv =====
// ----------------------------------------------------------------------------
// bpa_link_mem: next and prev link storage
// Two single-port arrays sharing one request; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_link_mem (
	input  wire logic                       clk,
	input  wire bpa_pkg::link_req_t         req,
	output logic [bpa_pkg::LinkW-1:0]       rdata
);
	logic [bpa_pkg::LinkW-1:0] next_mem [bpa_pkg::NumPages];
	logic [bpa_pkg::LinkW-1:0] prev_mem [bpa_pkg::NumPages];

	always_ff @(posedge clk) begin
		if (req.we) begin
			if (req.sel_prev) prev_mem[req.addr] <= req.wdata;
			else next_mem[req.addr] <= req.wdata;
		end
		rdata <= req.sel_prev ? prev_mem[req.addr] : next_mem[req.addr];
	end
endmodule
`default_nettype wire

// ===== rtl/bpa_pair_mem.sv =====
// ----------------------------------------------------------------------------
// bpa_pair_mem: buddy pair toggle bits
// One bit per pair in a memory with registered read data. After reset a
// clearing pass zeroes one entry per cycle; ready stays low
// until it is done.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_pair_mem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd,
	input  wire logic                      flip,
	input  wire logic [bpa_pkg::PageW-1:0] addr,
	output logic                           old,
	output logic                           ready
);
	logic                      bits_mem [bpa_pkg::NumPages];
	logic                      clr_q;
	logic [bpa_pkg::PageW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + bpa_pkg::PageW'(1);
			if (clr_addr_q == bpa_pkg::PageW'(bpa_pkg::NumPages - 1)) clr_q <= 1'b0;
		end
	end

	// flip writes back the inverse of the bit read in the previous cycle
	always_ff @(posedge clk) begin
		if (clr_q) bits_mem[clr_addr_q] <= 1'b0;
		else if (flip) bits_mem[addr] <= ~old;
		if (rd) old <= bits_mem[addr];
	end

	assign ready = !clr_q;
endmodule
`default_nettype wire
